// ===== rtl/smc_pkg.sv =====
package smc_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ROW  = 1'b1;

    localparam logic [1:0] SMOOTH_FWD = 2'd0;
    localparam logic [1:0] SMOOTH_CEN = 2'd1;
    localparam logic [1:0] SMOOTH_LAP = 2'd2;

    localparam logic [2:0] REG_TYPE     = 3'd0;
    localparam logic [2:0] REG_INDEXED  = 3'd1;
    localparam logic [2:0] REG_TOTAL    = 3'd2;
    localparam logic [2:0] REG_LOCAL    = 3'd3;
    localparam logic [2:0] REG_CHANNELS = 3'd4;
    localparam logic [2:0] REG_WEIGHT   = 3'd5;

    localparam int DVD_W = 13;
    localparam int DSR_W = 12;

    localparam logic [63:0] RHS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] RHS_MIN = 64'h8000_0000_0000_0000;

    typedef logic signed [15:0] pos_t;

    typedef struct packed {
        logic ok;
        pos_t left;
        pos_t mid;
        pos_t right;
    } cols_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DSR_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== rtl/smc_div.sv =====
module smc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  smc_pkg::div_req_t req,
    output smc_pkg::div_rsp_t rsp
);

    logic                       busy_reg;
    logic [3:0]                 count_reg;
    logic [smc_pkg::DVD_W-1:0]  quo_reg;
    logic [smc_pkg::DSR_W-1:0]  rem_reg;
    logic [smc_pkg::DSR_W-1:0]  dsr_reg;
    logic [smc_pkg::DVD_W-1:0]  trial;
    logic [smc_pkg::DVD_W-1:0]  diff;
    logic                       ge;

    // One restoring step per cycle: shift in the next dividend bit and try the subtract.
    assign trial = {rem_reg, quo_reg[smc_pkg::DVD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= 4'd0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= 4'(smc_pkg::DVD_W);
        end
        else if (busy_reg)
        begin
            if (count_reg != 4'd0)
            begin
                count_reg <= count_reg - 4'd1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg && (count_reg != 4'd0))
        begin
            quo_reg <= {quo_reg[smc_pkg::DVD_W-2:0], ge};
            rem_reg <= ge ? diff[smc_pkg::DSR_W-1:0] : trial[smc_pkg::DSR_W-1:0];
        end
    end

    assign rsp.done      = busy_reg && (count_reg == 4'd0);
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/smc_cols.sv =====
module smc_cols (
    input  logic [11:0]   idx,
    input  logic [11:0]   k,
    input  smc_pkg::pos_t shift,
    input  logic [1:0]    smoothing_type,
    input  logic          indexed_format,
    input  logic [12:0]   params_total,
    input  logic [11:0]   channels,
    input  smc_pkg::pos_t limit,
    output smc_pkg::cols_t cols
);

    always_comb
    begin
        smc_pkg::pos_t b;
        smc_pkg::pos_t p;
        smc_pkg::pos_t rw;
        smc_pkg::pos_t par;
        smc_pkg::pos_t l;
        smc_pkg::pos_t m;
        smc_pkg::pos_t r;
        logic          ok;
        logic          first;
        logic          last;

        b     = {4'd0, idx[11:1], 1'b0};
        p     = {3'd0, params_total};
        rw    = {4'd0, idx};
        par   = {15'd0, idx[0]};
        first = (k == 12'd0);
        last  = (k == (channels - 12'd1));
        ok    = 1'b0;
        l     = '1;
        m     = '1;
        r     = '1;

        // The decision is made for the real part; the imaginary part follows one column up.
        if ((rw < p) && ((smoothing_type == smc_pkg::SMOOTH_FWD) ||
                         (smoothing_type == smc_pkg::SMOOTH_CEN) ||
                         (smoothing_type == smc_pkg::SMOOTH_LAP)))
        begin
            if (smoothing_type == smc_pkg::SMOOTH_FWD)
            begin
                if (indexed_format || last)
                begin
                    if ((b + shift) < p)
                    begin
                        l  = b;
                        r  = b + shift;
                        ok = 1'b1;
                    end
                end
                else
                begin
                    l  = b;
                    r  = b + 16'sd2;
                    ok = 1'b1;
                end
            end
            else
            begin
                priority if (indexed_format || (first && last))
                begin
                    if (((b - shift) >= 16'sd0) && ((b + shift) < p))
                    begin
                        l  = b - shift;
                        r  = b + shift;
                        ok = 1'b1;
                    end
                end
                else if (first)
                begin
                    if ((b - shift) >= 16'sd0)
                    begin
                        l  = b - shift;
                        r  = b + 16'sd2;
                        ok = 1'b1;
                    end
                end
                else if (last)
                begin
                    if ((b + shift) < p)
                    begin
                        l  = b - 16'sd2;
                        r  = b + shift;
                        ok = 1'b1;
                    end
                end
                else
                begin
                    l  = b - 16'sd2;
                    r  = b + 16'sd2;
                    ok = 1'b1;
                end
            end

            if (ok)
            begin
                l = l + par;
                r = r + par;
                if (smoothing_type == smc_pkg::SMOOTH_LAP)
                begin
                    m = rw;
                end
                if ((l < 16'sd0) || (l >= limit) || (r < 16'sd0) || (r >= limit) ||
                    (m >= limit))
                begin
                    ok = 1'b0;
                end
            end
        end

        cols.ok    = ok;
        cols.left  = ok ? l : '1;
        cols.mid   = ok ? m : '1;
        cols.right = ok ? r : '1;
    end

endmodule

// ===== rtl/smoothness_constraint_rows_core.sv =====
// Smoothness constraint row builder over interleaved real/imaginary gain pairs.
// The input channel (in_valid/in_ready) carries one beat per item: a load beat
// writes one start-vector entry, a row beat produces one result beat on the
// output channel (out_valid/out_ready) with the three columns and the saturated
// right-hand side. The configuration channel (cfg_valid/cfg_ready) is always
// ready; the user must write it only while the core is idle, and the core
// itself does not enforce this. A load beat leaves the core ready for the
// next beat. A row beat runs a shared 13-step divider twice (channel quotient
// and channel index), then reads up to three start-vector entries through the
// single memory read port and multiplies by the weight in two passes of one
// 32x32 multiplier. The core is ready for the next beat in the cycle after
// the result is placed in the output register.
// The result is held in an output register, so a stalled receiver does not
// block further beats until the next row result is ready to be written there.
// Reset clears the configuration registers to their defaults and empties the
// output register; the start-vector memory is not cleared and holds undefined
// data until loaded.
module smoothness_constraint_rows_core #(
    parameter int MAX_PARAMS = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [11:0]        index,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [11:0]        row,
    output logic signed [12:0] left_col,
    output logic signed [12:0] mid_col,
    output logic signed [12:0] right_col,
    output logic signed [63:0] rhs,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int N_LIM  = (MAX_PARAMS < 4096) ? MAX_PARAMS : 4096;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIVQ = 4'd1;
    localparam logic [3:0] ST_DIVR = 4'd2;
    localparam logic [3:0] ST_COLS = 4'd3;
    localparam logic [3:0] ST_RD0  = 4'd4;
    localparam logic [3:0] ST_RD1  = 4'd5;
    localparam logic [3:0] ST_RD2  = 4'd6;
    localparam logic [3:0] ST_RD3  = 4'd7;
    localparam logic [3:0] ST_ERR  = 4'd8;
    localparam logic [3:0] ST_MUL0 = 4'd9;
    localparam logic [3:0] ST_MUL1 = 4'd10;
    localparam logic [3:0] ST_FIN  = 4'd11;

    logic [1:0]  type_reg;
    logic        indexed_reg;
    logic [12:0] total_reg;
    logic [12:0] local_reg;
    logic [11:0] channels_reg;
    logic [31:0] weight_reg;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic        out_valid_reg;

    logic [11:0]          idx_reg;
    logic [11:0]          k_reg;
    smc_pkg::pos_t        shift_reg;
    smc_pkg::cols_t       cols_reg;
    logic signed [31:0]   xl_reg;
    logic signed [31:0]   xr_reg;
    logic signed [31:0]   xm_reg;
    logic                 neg_reg;
    logic [33:0]          mag_reg;
    logic [63:0]          plo_reg;
    logic [33:0]          phi_reg;
    logic [31:0]          mem_q_reg;
    logic [31:0]          mem [MAX_PARAMS];

    logic [11:0]          row_reg;
    logic [12:0]          left_reg;
    logic [12:0]          mid_reg;
    logic [12:0]          right_reg;
    logic [63:0]          rhs_reg;

    logic                 in_fire;
    logic                 load_we;
    logic                 out_load;
    logic [11:0]          chan_eff;
    smc_pkg::pos_t        limit;
    smc_pkg::pos_t        shift_calc;
    smc_pkg::div_req_t    div_req;
    smc_pkg::div_rsp_t    div_rsp;
    smc_pkg::cols_t       cols_w;
    smc_pkg::pos_t        rd_col;
    logic [31:0]          rd_addr_w;
    logic [31:0]          wr_addr_w;
    logic signed [34:0]   err_w;
    logic [31:0]          mult_a;
    logic [63:0]          mult_p;
    logic [65:0]          prod_w;
    logic [63:0]          sat_w;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign load_we   = in_fire && (operation == smc_pkg::OP_LOAD) &&
                       ({20'd0, index} < 32'(MAX_PARAMS));
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    assign chan_eff  = (channels_reg == 12'd0) ? 12'd1 : channels_reg;
    assign limit     = ({3'd0, total_reg} < 16'(N_LIM)) ? {3'd0, total_reg} : 16'(N_LIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg     <= smc_pkg::SMOOTH_FWD;
            indexed_reg  <= 1'b0;
            total_reg    <= 13'd2;
            local_reg    <= 13'd2;
            channels_reg <= 12'd1;
            weight_reg   <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                smc_pkg::REG_TYPE:     type_reg     <= cfg_data[1:0];
                smc_pkg::REG_INDEXED:  indexed_reg  <= cfg_data[0];
                smc_pkg::REG_TOTAL:    total_reg    <= cfg_data[12:0];
                smc_pkg::REG_LOCAL:    local_reg    <= cfg_data[12:0];
                smc_pkg::REG_CHANNELS: channels_reg <= cfg_data[11:0];
                smc_pkg::REG_WEIGHT:   weight_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    // The divider first gives local/channels, then the channel of the pair.
    assign div_req.start    = (in_fire && (operation == smc_pkg::OP_ROW)) ||
                              ((state_reg == ST_DIVQ) && div_rsp.done);
    assign div_req.dividend = (state_reg == ST_IDLE) ? local_reg : {2'd0, idx_reg[11:1]};
    assign div_req.divisor  = chan_eff;

    smc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign shift_calc = indexed_reg ? {3'd0, div_rsp.quotient}
                                    : ({3'd0, local_reg} - {3'd0, chan_eff, 1'b0} + 16'sd2);

    smc_cols u_cols (
        .idx            (idx_reg),
        .k              (k_reg),
        .shift          (shift_reg),
        .smoothing_type (type_reg),
        .indexed_format (indexed_reg),
        .params_total   (total_reg),
        .channels       (chan_eff),
        .limit          (limit),
        .cols           (cols_w)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire && (operation == smc_pkg::OP_ROW)) state_next = ST_DIVQ;
            ST_DIVQ: if (div_rsp.done) state_next = ST_DIVR;
            ST_DIVR: if (div_rsp.done) state_next = ST_COLS;
            ST_COLS: state_next = cols_w.ok ? ST_RD0 : ST_FIN;
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:  state_next = ST_ERR;
            ST_ERR:  state_next = ST_MUL0;
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_FIN;
            ST_FIN:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_RD1:  rd_col = cols_reg.right;
            ST_RD2:  rd_col = (type_reg == smc_pkg::SMOOTH_LAP) ? cols_reg.mid : cols_reg.left;
            default: rd_col = cols_reg.left;
        endcase
    end

    assign rd_addr_w = {16'd0, rd_col};
    assign wr_addr_w = {20'd0, index};

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[wr_addr_w[ADDR_W-1:0]] <= value;
        end
        mem_q_reg <= mem[rd_addr_w[ADDR_W-1:0]];
    end

    assign err_w = (type_reg == smc_pkg::SMOOTH_LAP)
                 ? ((35'(xm_reg) <<< 1) - 35'(xl_reg) - 35'(xr_reg))
                 : (35'(xl_reg) - 35'(xr_reg));

    assign mult_a = (state_reg == ST_MUL0) ? mag_reg[31:0] : {30'd0, mag_reg[33:32]};
    assign mult_p = mult_a * weight_reg;
    assign prod_w = {2'd0, plo_reg} + {phi_reg, 32'd0};

    always_comb
    begin
        if (neg_reg)
        begin
            sat_w = (prod_w > {2'd0, smc_pkg::RHS_MIN}) ? smc_pkg::RHS_MIN
                                                        : (~prod_w[63:0] + 64'd1);
        end
        else
        begin
            sat_w = (prod_w > {2'd0, smc_pkg::RHS_MAX}) ? smc_pkg::RHS_MAX : prod_w[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            idx_reg <= index;
        end
        if ((state_reg == ST_DIVQ) && div_rsp.done)
        begin
            shift_reg <= shift_calc;
        end
        if ((state_reg == ST_DIVR) && div_rsp.done)
        begin
            k_reg <= div_rsp.remainder;
        end
        if (state_reg == ST_COLS)
        begin
            cols_reg <= cols_w;
        end
        if (state_reg == ST_RD1)
        begin
            xl_reg <= mem_q_reg;
        end
        if (state_reg == ST_RD2)
        begin
            xr_reg <= mem_q_reg;
        end
        if (state_reg == ST_RD3)
        begin
            xm_reg <= mem_q_reg;
        end
        if (state_reg == ST_ERR)
        begin
            neg_reg <= err_w[34];
            mag_reg <= err_w[34] ? 34'(-err_w) : 34'(err_w);
        end
        if (state_reg == ST_MUL0)
        begin
            plo_reg <= mult_p;
        end
        if (state_reg == ST_MUL1)
        begin
            phi_reg <= mult_p[33:0];
        end
        if (out_load)
        begin
            row_reg   <= idx_reg;
            left_reg  <= cols_reg.left[12:0];
            mid_reg   <= cols_reg.mid[12:0];
            right_reg <= cols_reg.right[12:0];
            rhs_reg   <= cols_reg.ok ? sat_w : 64'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign row       = row_reg;
    assign left_col  = left_reg;
    assign mid_col   = mid_reg;
    assign right_col = right_reg;
    assign rhs       = rhs_reg;

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (operation == smc_pkg::OP_LOAD) && !out_valid) |=> !out_valid)
        else $error("A load beat produced a result beat.");

    a_empty_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (left_col == 13'h1FFF)) |->
        ((right_col == 13'h1FFF) && (mid_col == 13'h1FFF) && (rhs == 64'sd0)))
        else $error("A row without a constraint carries columns or a right-hand side.");

    a_mid_is_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (mid_col != 13'h1FFF)) |-> (mid_col == {1'b0, row}))
        else $error("The middle column differs from the row index.");

    a_div_in_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ((state_reg == ST_DIVQ) || (state_reg == ST_DIVR)))
        else $error("The divider finished outside the division steps.");

endmodule

// ===== tb/smoothness_constraint_rows_check.sv =====
module smoothness_constraint_rows_check #(
    parameter int MAX_PARAMS = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               operation,
    input  logic [11:0]        index,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [11:0]        row,
    input  logic signed [12:0] left_col,
    input  logic signed [12:0] mid_col,
    input  logic signed [12:0] right_col,
    input  logic signed [63:0] rhs,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               drained,
    output int                 outstanding,
    output int                 fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [11:0] row;
        logic [12:0] left_col;
        logic [12:0] mid_col;
        logic [12:0] right_col;
        logic [63:0] rhs;
    } constraint_row_t;

    logic [1:0]  smooth_sel;
    logic        indexed_sel;
    logic [12:0] total_cnt;
    logic [12:0] local_cnt;
    logic [11:0] chan_cnt;
    logic [31:0] weight_q;
    logic [31:0] gain_mem [MAX_PARAMS];

    constraint_row_t rows_due [$];
    constraint_row_t want;
    int due_count = 0;
    int errors = 0;
    bit flushed = 1'b0;

    assign outstanding = due_count;
    assign fail_count = errors;

    task automatic report_fail(input string msg);
        $display("[%0t] %s", $time, msg);
        errors++;
    endtask

    function automatic longint gain_at(input longint pos);
        return longint'($signed(gain_mem[int'(pos)]));
    endfunction

    function automatic constraint_row_t build_row(input logic [11:0] idx);
        constraint_row_t res;
        longint p, n, c, b, par, k, s, l, m, r, e;
        logic signed [99:0] e_w, w_w, prod;
        bit ok, first_ch, last_ch;
        p = longint'(total_cnt);
        n = (p < MAX_PARAMS) ? p : MAX_PARAMS;
        if (n > 4096)
            n = 4096;
        c = (chan_cnt == '0) ? 1 : longint'(chan_cnt);
        b = longint'({idx[11:1], 1'b0});
        par = longint'(idx[0]);
        k = (b / 2) % c;
        s = indexed_sel ? longint'(local_cnt) / c : longint'(local_cnt) - (c - 1) * 2;
        first_ch = (k == 0);
        last_ch = (k == c - 1);
        l = -1;
        m = -1;
        r = -1;
        ok = 1'b0;
        if (longint'(idx) < p && smooth_sel <= smc_pkg::SMOOTH_LAP)
        begin
            if (smooth_sel == smc_pkg::SMOOTH_FWD)
            begin
                if (indexed_sel || last_ch)
                begin
                    if (b + s < p)
                    begin
                        l = b;
                        r = b + s;
                        ok = 1'b1;
                    end
                end
                else
                begin
                    l = b;
                    r = b + 2;
                    ok = 1'b1;
                end
            end
            else if (indexed_sel || (first_ch && last_ch))
            begin
                if (b - s >= 0 && b + s < p)
                begin
                    l = b - s;
                    r = b + s;
                    ok = 1'b1;
                end
            end
            else if (first_ch)
            begin
                if (b - s >= 0)
                begin
                    l = b - s;
                    r = b + 2;
                    ok = 1'b1;
                end
            end
            else if (last_ch)
            begin
                if (b + s < p)
                begin
                    l = b - 2;
                    r = b + s;
                    ok = 1'b1;
                end
            end
            else
            begin
                l = b - 2;
                r = b + 2;
                ok = 1'b1;
            end
            if (ok)
            begin
                l += par;
                r += par;
                if (smooth_sel == smc_pkg::SMOOTH_LAP)
                    m = longint'(idx);
                if (l < 0 || l >= n || r < 0 || r >= n || m >= n)
                    ok = 1'b0;
            end
        end
        res.row = idx;
        res.rhs = '0;
        if (!ok)
        begin
            l = -1;
            m = -1;
            r = -1;
        end
        else
        begin
            if (smooth_sel == smc_pkg::SMOOTH_LAP)
                e = -(gain_at(l) - 2 * gain_at(m) + gain_at(r));
            else
                e = gain_at(l) - gain_at(r);
            e_w = e;
            w_w = {68'd0, weight_q};
            prod = e_w * w_w;
            if (prod[99:63] == {37{prod[99]}})
                res.rhs = prod[63:0];
            else
                res.rhs = prod[99] ? smc_pkg::RHS_MIN : smc_pkg::RHS_MAX;
        end
        res.left_col = 13'(l);
        res.mid_col = 13'(m);
        res.right_col = 13'(r);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_sel <= smc_pkg::SMOOTH_FWD;
            indexed_sel <= 1'b0;
            total_cnt <= 13'd2;
            local_cnt <= 13'd2;
            chan_cnt <= 12'd1;
            weight_q <= '0;
            rows_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    smc_pkg::REG_TYPE:     smooth_sel <= cfg_data[1:0];
                    smc_pkg::REG_INDEXED:  indexed_sel <= cfg_data[0];
                    smc_pkg::REG_TOTAL:    total_cnt <= cfg_data[12:0];
                    smc_pkg::REG_LOCAL:    local_cnt <= cfg_data[12:0];
                    smc_pkg::REG_CHANNELS: chan_cnt <= cfg_data[11:0];
                    smc_pkg::REG_WEIGHT:   weight_q <= cfg_data;
                    default:               ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (operation == smc_pkg::OP_LOAD)
                begin
                    if (int'(index) < MAX_PARAMS)
                        gain_mem[index] <= value;
                end
                else
                    rows_due.push_back(build_row(index));
            end
            if (out_valid && out_ready)
            begin
                if (rows_due.size() == 0)
                    report_fail($sformatf("row %0d beat arrived with no row outstanding", row));
                else
                begin
                    want = rows_due.pop_front();
                    if (row !== want.row)
                        report_fail($sformatf("row: got %0d expected %0d", row, want.row));
                    if (left_col !== want.left_col)
                        report_fail($sformatf("row %0d left_col: got %h expected %h",
                                              want.row, left_col, want.left_col));
                    if (mid_col !== want.mid_col)
                        report_fail($sformatf("row %0d mid_col: got %h expected %h",
                                              want.row, mid_col, want.mid_col));
                    if (right_col !== want.right_col)
                        report_fail($sformatf("row %0d right_col: got %h expected %h",
                                              want.row, right_col, want.right_col));
                    if (rhs !== want.rhs)
                        report_fail($sformatf("row %0d rhs: got %h expected %h",
                                              want.row, rhs, want.rhs));
                end
            end
            if (drained && !flushed)
            begin
                flushed = 1'b1;
                while (rows_due.size() > 0)
                begin
                    want = rows_due.pop_front();
                    report_fail($sformatf("row %0d never delivered", want.row));
                end
            end
            due_count <= rows_due.size();
        end
    end

endmodule

// ===== tb/smoothness_constraint_rows_core_tb.sv =====
module smoothness_constraint_rows_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GAINS = 4096;
    localparam int IDLE_GAP = 40;
    localparam int PHASE_BEATS = 48;
    localparam logic [1:0] SMOOTH_NONE = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               operation = smc_pkg::OP_LOAD;
    logic [11:0]        index = '0;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [11:0]        row;
    logic signed [12:0] left_col;
    logic signed [12:0] mid_col;
    logic signed [12:0] right_col;
    logic signed [63:0] rhs;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = smc_pkg::REG_TYPE;
    logic [31:0]        cfg_data = '0;
    logic               drained = 1'b0;
    int                 outstanding;
    int                 fail_count;

    int tx_idle_pct = 24;
    int rx_idle_pct = 77;
    int beats_sent = 0;
    bit loaded [MAX_GAINS];
    logic        cur_indexed = 1'b0;
    logic [12:0] cur_total = 13'd2;
    logic [12:0] cur_local = 13'd2;
    logic [11:0] cur_chans = 12'd1;

    smoothness_constraint_rows_core #(
        .MAX_PARAMS(MAX_GAINS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .index(index),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .row(row),
        .left_col(left_col),
        .mid_col(mid_col),
        .right_col(right_col),
        .rhs(rhs),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    smoothness_constraint_rows_check #(
        .MAX_PARAMS(MAX_GAINS)
    ) row_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .index(index),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .row(row),
        .left_col(left_col),
        .mid_col(mid_col),
        .right_col(right_col),
        .rhs(rhs),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .drained(drained),
        .outstanding(outstanding),
        .fail_count(fail_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic send_beat(input logic op, input logic [11:0] idx, input logic [31:0] val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        index <= idx;
        value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    task automatic load_gain(input logic [11:0] pos, input logic [31:0] val);
        loaded[pos] = 1'b1;
        send_beat(smc_pkg::OP_LOAD, pos, val);
    endtask

    // A row may read the entries at its neighbor positions, so any of them
    // not loaded since reset gets a load beat first.
    task automatic request_row(input logic [11:0] idx);
        longint chans, shift, base, pos;
        longint offs [5];
        chans = (cur_chans == '0) ? 1 : longint'(cur_chans);
        shift = cur_indexed ? longint'(cur_local) / chans
                            : longint'(cur_local) - 2 * (chans - 1);
        base = longint'({idx[11:1], 1'b0}) + longint'(idx[0]);
        offs = '{-shift, -2, 0, 2, shift};
        foreach (offs[j])
        begin
            pos = base + offs[j];
            if (pos >= 0 && pos < MAX_GAINS && !loaded[pos])
                load_gain(12'(pos), rand_gain());
        end
        send_beat(smc_pkg::OP_ROW, idx, $urandom());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            smc_pkg::REG_INDEXED:  cur_indexed = data[0];
            smc_pkg::REG_TOTAL:    cur_total = data[12:0];
            smc_pkg::REG_LOCAL:    cur_local = data[12:0];
            smc_pkg::REG_CHANNELS: cur_chans = data[11:0];
            default:               ;
        endcase
    endtask

    task automatic apply_settings(input logic [1:0] kind, input logic fmt,
                                  input logic [12:0] total, input logic [12:0] per_block,
                                  input logic [11:0] chans, input logic [31:0] w);
        logic [31:0] junk;
        junk = $urandom();
        wait_idle();
        write_reg(smc_pkg::REG_TYPE, {junk[31:2], kind});
        write_reg(smc_pkg::REG_INDEXED, {junk[31:1], fmt});
        write_reg(smc_pkg::REG_TOTAL, {junk[31:13], total});
        write_reg(smc_pkg::REG_LOCAL, {junk[31:13], per_block});
        write_reg(smc_pkg::REG_CHANNELS, {junk[31:12], chans});
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
        write_reg(smc_pkg::REG_WEIGHT, w);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings();
        logic [1:0]  kind;
        logic [12:0] total, per_block;
        logic [11:0] chans;
        logic [31:0] w;
        case ($urandom_range(19))
            0:       kind = SMOOTH_NONE;
            1, 2, 3, 4, 5, 6: kind = smc_pkg::SMOOTH_FWD;
            7, 8, 9, 10, 11, 12: kind = smc_pkg::SMOOTH_CEN;
            default: kind = smc_pkg::SMOOTH_LAP;
        endcase
        case ($urandom_range(9))
            0:       total = 13'd4096;
            1:       total = 13'($urandom_range(4097, 8191));
            2:       total = 13'($urandom_range(3, 63));
            default: total = 13'(2 * $urandom_range(1, 32));
        endcase
        case ($urandom_range(7))
            0:       per_block = 13'($urandom());
            1:       per_block = 13'($urandom_range(0, 1));
            default: per_block = 13'(2 * $urandom_range(1, 16));
        endcase
        case ($urandom_range(7))
            0:       chans = 12'd0;
            1:       chans = 12'($urandom());
            default: chans = 12'($urandom_range(1, 8));
        endcase
        case ($urandom_range(5))
            0:       w = 32'h0;
            1:       w = 32'hFFFF_FFFF;
            2:       w = $urandom_range(1, 1024);
            default: w = $urandom();
        endcase
        apply_settings(kind, 1'($urandom_range(1)), total, per_block, chans, w);
    endtask

    initial
    begin
        int lim;
        int phase_start;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_gain(12'd0, 32'h7FFF_FFFF);
        load_gain(12'd1, 32'h8000_0000);
        request_row(12'd0);
        request_row(12'd1);
        request_row(12'd4095);

        apply_settings(smc_pkg::SMOOTH_LAP, 1'b1, 13'd16, 13'd8, 12'd4, 32'hFFFF_FFFF);
        load_gain(12'd0, 32'h8000_0000);
        load_gain(12'd2, 32'h7FFF_FFFF);
        load_gain(12'd4, 32'h8000_0000);
        load_gain(12'd1, 32'h7FFF_FFFF);
        load_gain(12'd3, 32'h8000_0000);
        load_gain(12'd5, 32'h7FFF_FFFF);
        request_row(12'd2);
        request_row(12'd3);
        request_row(12'd0);
        request_row(12'd15);

        apply_settings(smc_pkg::SMOOTH_FWD, 1'b0, 13'd8191, 13'd2, 12'd0, 32'h0000_0100);
        request_row(12'd4);

        apply_settings(SMOOTH_NONE, 1'b1, 13'd16, 13'd4, 12'd2, 32'h0000_0100);
        request_row(12'd4);

        apply_settings(smc_pkg::SMOOTH_CEN, 1'b0, 13'd16, 13'd2, 12'd4, 32'h0000_0100);
        request_row(12'd0);
        request_row(12'd7);
        request_row(12'd2);

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph < 4)
            begin
                tx_idle_pct = 24;
                rx_idle_pct = 77;
            end
            else if (ph < 8)
            begin
                tx_idle_pct = 77;
                rx_idle_pct = 24;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (ph == 0)
                apply_settings(smc_pkg::SMOOTH_CEN, 1'b1, 13'd4096, 13'd4096, 12'd2048,
                               32'hFFFF_FFFF);
            else if (ph == 1)
                apply_settings(smc_pkg::SMOOTH_LAP, 1'b0, 13'd8191, 13'd8191, 12'd4095,
                               32'd1);
            else
                random_settings();
            lim = (cur_total > 13'd4095) ? 4095 : int'(cur_total) + 1;
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
            begin
                if ($urandom_range(3) == 0)
                    load_gain(12'($urandom_range(0, lim)), rand_gain());
                else if ($urandom_range(4) == 0)
                    request_row(12'($urandom()));
                else
                    request_row(12'($urandom_range(0, lim)));
            end
        end

        wait_idle();
        drained <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
